/* design/segment_obb_overlap_test_defines.svh */
// assertion macros for the segment versus box overlap design
`ifndef SEGMENT_OBB_OVERLAP_TEST_DEFINES_SVH
`define SEGMENT_OBB_OVERLAP_TEST_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define SOBB_ASSERT_IMPLIES(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define SOBB_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* design/sobb_pkg.sv */
// shared types, constants and helpers for the segment versus box overlap test
`timescale 1ns / 1ps

package sobb_pkg;

  // pipeline depth, one register stage each
  localparam int unsigned NUM_STAGES = 6;

  // packed field widths
  localparam int unsigned COMP_W = 16;
  localparam int unsigned VEC_W  = 48;
  localparam int unsigned LEN_W  = 15;

  // cyclic neighbor indexes for the cross axes
  localparam int J_IDX [3] = '{1, 2, 0};
  localparam int K_IDX [3] = '{2, 0, 1};

  typedef logic signed [COMP_W-1:0] comp_t;

  // per-stage advance strobes from the handshake control to the datapath
  typedef struct packed {
    logic [NUM_STAGES-1:0] adv;
  } stage_ctrl_t;

  // one signed 16-bit component out of a packed xyz word
  function automatic comp_t comp(input logic [VEC_W-1:0] word, input int k);
    return comp_t'(word[k*COMP_W +: COMP_W]);
  endfunction

endpackage

/* design/sobb_core.sv */
// six-stage exact-arithmetic datapath of the separating-axis test
`timescale 1ns / 1ps

module sobb_core (
  input  logic                                 clk,
  input  sobb_pkg::stage_ctrl_t                ctrl,
  input  logic [sobb_pkg::VEC_W-1:0]           seg_center_xyz,
  input  logic [sobb_pkg::VEC_W-1:0]           seg_dir_xyz,
  input  logic [sobb_pkg::LEN_W-1:0]           seg_half_length,
  input  logic [sobb_pkg::VEC_W-1:0]           box_center_xyz,
  input  logic [sobb_pkg::VEC_W-1:0]           box_axis_a_xyz,
  input  logic [sobb_pkg::VEC_W-1:0]           box_axis_b_xyz,
  input  logic [sobb_pkg::VEC_W-1:0]           box_axis_c_xyz,
  input  logic [sobb_pkg::VEC_W-1:0]           box_half_sizes,
  output logic                                 overlaps
);

  logic [sobb_pkg::VEC_W-1:0] axis_w [3];

  assign axis_w[0] = box_axis_a_xyz;
  assign axis_w[1] = box_axis_b_xyz;
  assign axis_w[2] = box_axis_c_xyz;

  // stage 1: unpack, center difference
  sobb_pkg::comp_t             w1_r   [3], w1_nxt   [3];
  logic signed [16:0]          d1_r   [3], d1_nxt   [3];
  sobb_pkg::comp_t             ax1_r  [3][3], ax1_nxt [3][3];
  logic [sobb_pkg::COMP_W-1:0] ext1_r [3], ext1_nxt [3];
  logic [sobb_pkg::LEN_W-1:0]  e1_r, e1_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      w1_nxt[k]   = sobb_pkg::comp(seg_dir_xyz, k);
      d1_nxt[k]   = 17'(sobb_pkg::comp(seg_center_xyz, k))
                  - 17'(sobb_pkg::comp(box_center_xyz, k));
      ext1_nxt[k] = box_half_sizes[k*sobb_pkg::COMP_W +: sobb_pkg::COMP_W];
      for (int i = 0; i < 3; i++) begin
        ax1_nxt[i][k] = sobb_pkg::comp(axis_w[i], k);
      end
    end
    e1_nxt = seg_half_length;
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[0]) begin
      w1_r   <= w1_nxt;
      d1_r   <= d1_nxt;
      ax1_r  <= ax1_nxt;
      ext1_r <= ext1_nxt;
      e1_r   <= e1_nxt;
    end
  end

  // stage 2: component products for the dots and the cross product
  logic signed [31:0]          pwu2_r [3][3], pwu2_nxt [3][3];
  logic signed [32:0]          pdu2_r [3][3], pdu2_nxt [3][3];
  logic signed [32:0]          pcp2_r [3], pcp2_nxt [3];
  logic signed [32:0]          pcn2_r [3], pcn2_nxt [3];
  sobb_pkg::comp_t             ax2_r  [3][3];
  logic [sobb_pkg::COMP_W-1:0] ext2_r [3];
  logic [sobb_pkg::LEN_W-1:0]  e2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        pwu2_nxt[i][k] = w1_r[k] * ax1_r[i][k];
        pdu2_nxt[i][k] = d1_r[k] * ax1_r[i][k];
      end
    end
    for (int k = 0; k < 3; k++) begin
      pcp2_nxt[k] = w1_r[sobb_pkg::J_IDX[k]] * d1_r[sobb_pkg::K_IDX[k]];
      pcn2_nxt[k] = w1_r[sobb_pkg::K_IDX[k]] * d1_r[sobb_pkg::J_IDX[k]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[1]) begin
      pwu2_r <= pwu2_nxt;
      pdu2_r <= pdu2_nxt;
      pcp2_r <= pcp2_nxt;
      pcn2_r <= pcn2_nxt;
      ax2_r  <= ax1_r;
      ext2_r <= ext1_r;
      e2_r   <= e1_r;
    end
  end

  // stage 3: dot sums with magnitude, cross product components
  logic [31:0]                 awu3_r [3], awu3_nxt [3];
  logic [32:0]                 adu3_r [3], adu3_nxt [3];
  logic signed [32:0]          x3_r   [3], x3_nxt   [3];
  sobb_pkg::comp_t             ax3_r  [3][3];
  logic [sobb_pkg::COMP_W-1:0] ext3_r [3];
  logic [sobb_pkg::LEN_W-1:0]  e3_r;

  always_comb begin
    logic signed [33:0] swu;
    logic signed [34:0] sdu;
    for (int i = 0; i < 3; i++) begin
      swu = 34'(pwu2_r[i][0]) + 34'(pwu2_r[i][1]) + 34'(pwu2_r[i][2]);
      sdu = 35'(pdu2_r[i][0]) + 35'(pdu2_r[i][1]) + 35'(pdu2_r[i][2]);
      awu3_nxt[i] = swu[33] ? 32'(-swu) : swu[31:0];
      adu3_nxt[i] = sdu[34] ? 33'(-sdu) : sdu[32:0];
      x3_nxt[i]   = pcp2_r[i] - pcn2_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[2]) begin
      awu3_r <= awu3_nxt;
      adu3_r <= adu3_nxt;
      x3_r   <= x3_nxt;
      ax3_r  <= ax2_r;
      ext3_r <= ext2_r;
      e3_r   <= e2_r;
    end
  end

  // stage 4: radius products and cross-axis projection products
  logic [46:0]                 ewu4_r [3], ewu4_nxt [3];
  logic [47:0]                 exa4_r [3], exa4_nxt [3];
  logic [47:0]                 exb4_r [3], exb4_nxt [3];
  logic signed [48:0]          pxa4_r [3][3], pxa4_nxt [3][3];
  logic [32:0]                 adu4_r [3];
  logic [sobb_pkg::COMP_W-1:0] ext4_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ewu4_nxt[i] = 47'(e3_r) * 47'(awu3_r[i]);
      exa4_nxt[i] = 48'(ext3_r[sobb_pkg::J_IDX[i]]) * 48'(awu3_r[sobb_pkg::K_IDX[i]]);
      exb4_nxt[i] = 48'(ext3_r[sobb_pkg::K_IDX[i]]) * 48'(awu3_r[sobb_pkg::J_IDX[i]]);
      for (int k = 0; k < 3; k++) begin
        pxa4_nxt[i][k] = x3_r[k] * ax3_r[i][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[3]) begin
      ewu4_r <= ewu4_nxt;
      exa4_r <= exa4_nxt;
      exb4_r <= exb4_nxt;
      pxa4_r <= pxa4_nxt;
      adu4_r <= adu3_r;
      ext4_r <= ext3_r;
    end
  end

  // stage 5: both sides of every axis test at scale 2^36
  logic [46:0]        lhs5_r [3], lhs5_nxt [3];
  logic [47:0]        rhs5_r [3], rhs5_nxt [3];
  logic signed [49:0] sx5_r  [3], sx5_nxt  [3];
  logic [48:0]        rcx5_r [3], rcx5_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lhs5_nxt[i] = {adu4_r[i], 14'd0};
      rhs5_nxt[i] = 48'({ext4_r[i], 28'd0}) + 48'(ewu4_r[i]);
      sx5_nxt[i]  = 50'(pxa4_r[i][0]) + 50'(pxa4_r[i][1]) + 50'(pxa4_r[i][2]);
      rcx5_nxt[i] = 49'(exa4_r[i]) + 49'(exb4_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[4]) begin
      lhs5_r <= lhs5_nxt;
      rhs5_r <= rhs5_nxt;
      sx5_r  <= sx5_nxt;
      rcx5_r <= rcx5_nxt;
    end
  end

  // stage 6: compares, any strictly greater distance separates
  logic ovl6_r, ovl6_nxt;

  always_comb begin
    logic [48:0] lcx;
    logic        sep;
    sep = 1'b0;
    for (int i = 0; i < 3; i++) begin
      lcx = sx5_r[i][49] ? 49'(-sx5_r[i]) : sx5_r[i][48:0];
      if (48'(lhs5_r[i]) > rhs5_r[i]) sep = 1'b1;
      if (lcx > rcx5_r[i])            sep = 1'b1;
    end
    ovl6_nxt = !sep;
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[5]) begin
      ovl6_r <= ovl6_nxt;
    end
  end

  assign overlaps = ovl6_r;

endmodule

/* design/segment_obb_overlap_test.sv */
// top level of the segment versus oriented box overlap test
`timescale 1ns / 1ps
`include "segment_obb_overlap_test_defines.svh"

// Segment versus oriented box overlap test by separating axes. Each transfer
// carries one segment and one box and yields one overlaps bit, in order. The
// block is a six-stage pipeline (unpack and difference, component products,
// dot sums, radius and cross-axis products, side sums, compares) and takes
// one item per cycle while in_stall is low. The input transfer loads the
// first stage, and each result moves through the stage registers in order
// to out_valid and out_overlaps. Each stage has its own valid bit and
// advances when it is empty or the stage after it advances, so bubbles close
// up while out_stall is high and the input stalls only when every stage is
// full and the output is held. Arithmetic is exact; touching counts as overlap.

module segment_obb_overlap_test (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [sobb_pkg::VEC_W-1:0] in_seg_center_xyz,
  input  logic [sobb_pkg::VEC_W-1:0] in_seg_dir_xyz,
  input  logic [sobb_pkg::LEN_W-1:0] in_seg_half_length,
  input  logic [sobb_pkg::VEC_W-1:0] in_box_center_xyz,
  input  logic [sobb_pkg::VEC_W-1:0] in_box_axis_a_xyz,
  input  logic [sobb_pkg::VEC_W-1:0] in_box_axis_b_xyz,
  input  logic [sobb_pkg::VEC_W-1:0] in_box_axis_c_xyz,
  input  logic [sobb_pkg::VEC_W-1:0] in_box_half_sizes,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_overlaps
);

  localparam int unsigned LAST = sobb_pkg::NUM_STAGES - 1;

  logic [sobb_pkg::NUM_STAGES-1:0] vld_r, vld_nxt;
  sobb_pkg::stage_ctrl_t           ctrl;

  // advance chain, from the output back to the input
  always_comb begin
    ctrl.adv[LAST] = !vld_r[LAST] || !out_stall;
    for (int s = int'(LAST) - 1; s >= 0; s--) begin
      ctrl.adv[s] = !vld_r[s] || ctrl.adv[s+1];
    end
  end

  // valid bits move with their stage
  always_comb begin
    vld_nxt[0] = ctrl.adv[0] ? in_valid : vld_r[0];
    for (int s = 1; s < int'(sobb_pkg::NUM_STAGES); s++) begin
      vld_nxt[s] = ctrl.adv[s] ? vld_r[s-1] : vld_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !ctrl.adv[0];
  assign out_valid = vld_r[LAST];

  // arithmetic pipeline
  sobb_core u_core (
    .clk             (clk),
    .ctrl            (ctrl),
    .seg_center_xyz  (in_seg_center_xyz),
    .seg_dir_xyz     (in_seg_dir_xyz),
    .seg_half_length (in_seg_half_length),
    .box_center_xyz  (in_box_center_xyz),
    .box_axis_a_xyz  (in_box_axis_a_xyz),
    .box_axis_b_xyz  (in_box_axis_b_xyz),
    .box_axis_c_xyz  (in_box_axis_c_xyz),
    .box_half_sizes  (in_box_half_sizes),
    .overlaps        (out_overlaps)
  );

  // pipeline control checks
  `SOBB_ASSERT_IMPLIES(a_stall_only_when_blocked, in_stall, out_valid && out_stall,
                       "input stalled without a held result")
  `SOBB_ASSERT_IMPLIES(a_full_pipe_stalls, (&vld_r) && out_stall, in_stall,
                       "full pipeline took an input transfer")
  `SOBB_ASSERT_NEXT(a_accept_fills_first, in_valid && !in_stall, vld_r[0],
                    "accepted transfer not in first stage")
  `SOBB_ASSERT_NEXT(a_no_invented_result, !out_valid && !vld_r[LAST-1], !out_valid,
                    "result with no item behind it")

endmodule

/* verif/segment_obb_overlap_test_tb.sv */
// testbench for the segment versus oriented box overlap test
`timescale 1ns / 1ps

typedef logic [sobb_pkg::VEC_W-1:0] xyz_t;

// one segment and one box, as carried by a single input transfer
typedef struct {
  xyz_t                       seg_center;
  xyz_t                       seg_dir;
  logic [sobb_pkg::LEN_W-1:0] seg_half_length;
  xyz_t                       box_center;
  xyz_t                       box_axis [3];
  xyz_t                       box_half_sizes;
} seg_box_t;

typedef longint vec3_t [3];

// predicts the overlaps bit of each accepted item and checks results in order
class overlap_scoreboard;
  bit          expected_overlaps [$];
  int unsigned errors;
  int unsigned results_seen;

  function new();
    errors = 0;
    results_seen = 0;
  endfunction

  static function longint comp_at(xyz_t word, int k);
    logic signed [sobb_pkg::COMP_W-1:0] c;
    c = word[k*sobb_pkg::COMP_W +: sobb_pkg::COMP_W];
    return longint'(c);
  endfunction

  static function longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  static function longint dot3(vec3_t a, vec3_t b);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  // separating-axis test, every comparison at scale 2^36
  function bit overlap_of(seg_box_t it);
    vec3_t  w, d, x, ax [3];
    longint ext [3], awu [3];
    longint e, lhs, rhs;
    bit     separated;
    separated = 1'b0;
    e = longint'(it.seg_half_length);
    for (int k = 0; k < 3; k++) begin
      w[k] = comp_at(it.seg_dir, k);
      d[k] = comp_at(it.seg_center, k) - comp_at(it.box_center, k);
      ext[k] = longint'(it.box_half_sizes[k*sobb_pkg::COMP_W +: sobb_pkg::COMP_W]);
      for (int i = 0; i < 3; i++)
        ax[i][k] = comp_at(it.box_axis[i], k);
    end
    // box axes
    for (int i = 0; i < 3; i++) begin
      awu[i] = mag(dot3(w, ax[i]));
      lhs = mag(dot3(d, ax[i])) * 16384;
      rhs = ext[i] * (longint'(1) << 28) + e * awu[i];
      if (lhs > rhs)
        separated = 1'b1;
    end
    // cross axes, direction times each box axis
    x[0] = w[1] * d[2] - w[2] * d[1];
    x[1] = w[2] * d[0] - w[0] * d[2];
    x[2] = w[0] * d[1] - w[1] * d[0];
    for (int i = 0; i < 3; i++) begin
      lhs = mag(dot3(x, ax[i]));
      rhs = ext[(i + 1) % 3] * awu[(i + 2) % 3] + ext[(i + 2) % 3] * awu[(i + 1) % 3];
      if (lhs > rhs)
        separated = 1'b1;
    end
    return !separated;
  endfunction

  function void note_input(seg_box_t it);
    expected_overlaps.push_back(overlap_of(it));
  endfunction

  function int pending();
    return expected_overlaps.size();
  endfunction

  task report(string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  task check_result(logic got);
    bit want;
    results_seen++;
    if (expected_overlaps.size() == 0) begin
      report($sformatf("result %0d arrived with no item outstanding", results_seen));
    end else begin
      want = expected_overlaps.pop_front();
      if (got !== want)
        report($sformatf("result %0d overlaps got %b expected %b", results_seen, got, want));
    end
  endtask
endclass

module segment_obb_overlap_test_tb;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  localparam int  NUM_ITEMS        = 1800;
  localparam int  LONG_HOLD_CYCLES = 200;
  localparam int  SETTLE_CYCLES    = 4 * sobb_pkg::NUM_STAGES;
  localparam int  ONE_Q14          = 16384;
  localparam int  ONE_Q78          = 256;
  localparam real HALF_PI          = 1.5707963267948966;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  xyz_t                       in_seg_center_xyz = '0;
  xyz_t                       in_seg_dir_xyz = '0;
  logic [sobb_pkg::LEN_W-1:0] in_seg_half_length = '0;
  xyz_t                       in_box_center_xyz = '0;
  xyz_t                       in_box_axis_a_xyz = '0;
  xyz_t                       in_box_axis_b_xyz = '0;
  xyz_t                       in_box_axis_c_xyz = '0;
  xyz_t                       in_box_half_sizes = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_overlaps;

  logic                       hold_request = 1'b0;
  int unsigned                hold_left = 0;
  int unsigned                rx_cycle = 0;
  stall_mode_t                stall_mode = STALL_NONE;
  int unsigned                items_sent = 0;
  overlap_scoreboard          scoreboard;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_obb_overlap_test dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_seg_center_xyz  (in_seg_center_xyz),
    .in_seg_dir_xyz     (in_seg_dir_xyz),
    .in_seg_half_length (in_seg_half_length),
    .in_box_center_xyz  (in_box_center_xyz),
    .in_box_axis_a_xyz  (in_box_axis_a_xyz),
    .in_box_axis_b_xyz  (in_box_axis_b_xyz),
    .in_box_axis_c_xyz  (in_box_axis_c_xyz),
    .in_box_half_sizes  (in_box_half_sizes),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_overlaps       (out_overlaps)
  );

  function automatic xyz_t pack3(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  // move component k of v to position (k + r) mod 3
  function automatic xyz_t spin(xyz_t v, int r);
    xyz_t s;
    for (int k = 0; k < 3; k++)
      s[((k + r) % 3)*16 +: 16] = v[k*16 +: 16];
    return s;
  endfunction

  function automatic real random_angle();
    if ($urandom_range(0, 3) == 0)
      return HALF_PI * $urandom_range(0, 3);
    return 4.0 * HALF_PI * $urandom_range(0, 65535) / 65536.0;
  endfunction

  // mostly a rotated box near a segment, some fully random noise
  function automatic seg_box_t random_item();
    seg_box_t it;
    int       ax [3][3];
    int       bc [3];
    int       sc [3];
    int       hs [3];
    int       spread, turn, p, q, s, cs, sn;
    real      theta, phi, psi;
    if ($urandom_range(0, 99) < 12) begin
      it.seg_center      = 48'({$urandom, $urandom});
      it.seg_dir         = 48'({$urandom, $urandom});
      it.seg_half_length = 15'($urandom);
      it.box_center      = 48'({$urandom, $urandom});
      it.box_half_sizes  = 48'({$urandom, $urandom});
      for (int i = 0; i < 3; i++)
        it.box_axis[i] = 48'({$urandom, $urandom});
      return it;
    end
    // box frame: rotation about one coordinate axis
    theta = random_angle();
    cs = int'($cos(theta) * ONE_Q14);
    sn = int'($sin(theta) * ONE_Q14);
    p = $urandom_range(0, 2);
    q = (p + 1) % 3;
    s = (p + 2) % 3;
    ax = '{default: 0};
    ax[0][q] = cs;
    ax[0][s] = sn;
    ax[1][q] = -sn;
    ax[1][s] = cs;
    ax[2][p] = ONE_Q14;
    turn = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      it.box_axis[(i + turn) % 3] = ($urandom_range(0, 1) == 1)
          ? pack3(-ax[i][0], -ax[i][1], -ax[i][2]) : pack3(ax[i][0], ax[i][1], ax[i][2]);
      if ($urandom_range(0, 19) == 0)
        it.box_axis[(i + turn) % 3] = 48'({$urandom, $urandom});
    end
    // segment direction
    phi = random_angle();
    psi = random_angle();
    it.seg_dir = pack3(int'($cos(phi) * $cos(psi) * ONE_Q14),
                       int'($sin(phi) * $cos(psi) * ONE_Q14), int'($sin(psi) * ONE_Q14));
    if ($urandom_range(0, 11) == 0)
      it.seg_dir = 48'({$urandom, $urandom});
    // placement and sizes
    case ($urandom_range(0, 2))
      0:       spread = ONE_Q78;
      1:       spread = 4 * ONE_Q78;
      default: spread = 12 * ONE_Q78;
    endcase
    for (int k = 0; k < 3; k++) begin
      bc[k] = int'($urandom_range(0, 16000)) - 8000;
      sc[k] = bc[k] + int'($urandom_range(0, 2 * spread)) - spread;
      hs[k] = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 65535))
                                           : int'($urandom_range(0, 4 * ONE_Q78));
    end
    it.box_center      = pack3(bc[0], bc[1], bc[2]);
    it.seg_center      = pack3(sc[0], sc[1], sc[2]);
    it.box_half_sizes  = pack3(hs[0], hs[1], hs[2]);
    it.seg_half_length = 15'($urandom_range(0, 8 * ONE_Q78));
    return it;
  endfunction

  // one input transfer, held until accepted
  task automatic send_item(input seg_box_t it);
    in_valid           <= 1'b1;
    in_seg_center_xyz  <= it.seg_center;
    in_seg_dir_xyz     <= it.seg_dir;
    in_seg_half_length <= it.seg_half_length;
    in_box_center_xyz  <= it.box_center;
    in_box_axis_a_xyz  <= it.box_axis[0];
    in_box_axis_b_xyz  <= it.box_axis[1];
    in_box_axis_c_xyz  <= it.box_axis[2];
    in_box_half_sizes  <= it.box_half_sizes;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    scoreboard.note_input(it);
    items_sent++;
  endtask

  task automatic send_direct(xyz_t sc, xyz_t sd, logic [sobb_pkg::LEN_W-1:0] e, xyz_t bc,
                             xyz_t a, xyz_t b, xyz_t c, xyz_t hs);
    seg_box_t it;
    it.seg_center      = sc;
    it.seg_dir         = sd;
    it.seg_half_length = e;
    it.box_center      = bc;
    it.box_axis[0]     = a;
    it.box_axis[1]     = b;
    it.box_axis[2]     = c;
    it.box_half_sizes  = hs;
    send_item(it);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    do
      @(posedge clk);
    while (scoreboard.pending() != 0);
  endtask

  task automatic run_directed();
    xyz_t ex, ey, ez, unit;
    ex   = pack3(ONE_Q14, 0, 0);
    ey   = pack3(0, ONE_Q14, 0);
    ez   = pack3(0, 0, ONE_Q14);
    unit = pack3(ONE_Q78, ONE_Q78, ONE_Q78);
    // all zero, then all ones
    send_direct('0, '0, '0, '0, '0, '0, '0, '0);
    send_direct('1, '1, '1, '1, '1, '1, '1, '1);
    // segment through the middle of a unit box
    send_direct('0, ex, 15'(ONE_Q78), '0, ex, ey, ez, unit);
    // separated along each box axis in turn
    for (int k = 0; k < 3; k++)
      send_direct(spin(pack3(3 * ONE_Q78, 0, 0), k), spin(ey, k), 15'(ONE_Q78 / 2), '0,
                  ex, ey, ez, unit);
    // exactly touching, then one step past
    send_direct(pack3(2 * ONE_Q78, 0, 0), ex, 15'(ONE_Q78), '0, ex, ey, ez, unit);
    send_direct(pack3(2 * ONE_Q78 + 1, 0, 0), ex, 15'(ONE_Q78), '0, ex, ey, ez, unit);
    // passing a box edge, separated only by a cross axis
    for (int k = 0; k < 3; k++)
      send_direct(spin(pack3(410, 410, 0), k), spin(pack3(11585, -11585, 0), k),
                  15'(4 * ONE_Q78), '0, ex, ey, ez, unit);
    // zero direction inside and outside
    send_direct('0, '0, 15'h7FFF, '0, ex, ey, ez, unit);
    send_direct(pack3(4 * ONE_Q78, 0, 0), '0, 15'h7FFF, '0, ex, ey, ez, unit);
    // zero box axes never separate
    send_direct(pack3(8000, 8000, 8000), ex, '0, '0, '0, '0, '0, '0);
    // vectors far from unit length
    send_direct(pack3(100, -50, 20), pack3(-32768, -32768, -32768), 15'(300), '0,
                pack3(32767, 0, -32768), pack3(32767, 32767, 32767), pack3(1, -1, 0), unit);
    // widest center difference, zero and full extents
    send_direct(pack3(32767, 32767, 32767), ex, '0, pack3(-32768, -32768, -32768),
                ex, ey, ez, '0);
    send_direct(pack3(32767, 32767, 32767), ex, 15'h7FFF, pack3(-32768, -32768, -32768),
                ex, ey, ez, '1);
    // box turned half a right angle
    send_direct(pack3(400, 0, 0), ez, 15'(ONE_Q78), '0, pack3(11585, 11585, 0),
                pack3(-11585, 11585, 0), ez, unit);
    // longest segment reaching the box
    send_direct(pack3(0, 0, -32768), ez, 15'h7FFF, '0, ex, ey, ez, unit);
  endtask

  task automatic run_random();
    int          burst, gap;
    bit          held, paused;
    int unsigned target;
    held = 1'b0;
    paused = 1'b0;
    target = items_sent + NUM_ITEMS;
    while (items_sent < target) begin
      if (!held && items_sent + 2 * NUM_ITEMS / 3 >= target) begin
        // output held off for a long stretch while a solid burst is offered
        held = 1'b1;
        hold_request <= 1'b1;
        burst = 60;
      end else begin
        burst = $urandom_range(1, 30);
      end
      for (int n = 0; n < burst; n++)
        send_item(random_item());
      if (!paused && items_sent + NUM_ITEMS / 3 >= target) begin
        paused = 1'b1;
        drain_results();
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // result side: check each transfer and drive the stall pattern
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        scoreboard.check_result(out_overlaps);
      rx_cycle++;
      if (rx_cycle % 256 == 0)
        stall_mode = stall_mode_t'($urandom_range(0, 3));
      if (hold_request) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_request <= 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
          default:     out_stall <= (rx_cycle % 7 < 3);
        endcase
      end
    end
  end

  // main sequence
  initial begin
    scoreboard = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    drain_results();
    run_random();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (scoreboard.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // run limit
  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
